### design/dcrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrd_pkg: shared types and constants of the capture record decoder
// Action and status codes, group layout constants, the command word passed
// from the front end to the back end, and the state machine types.
// ----------------------------------------------------------------------------
package dcrd_pkg;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int ADDR_W   = 7;
    localparam int RESULT_W = 33;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 20;

    // Action codes
    localparam logic [2:0] ACT_STORE     = 3'd0;
    localparam logic [2:0] ACT_DIGITAL   = 3'd1;
    localparam logic [2:0] ACT_ENCODER   = 3'd2;
    localparam logic [2:0] ACT_ANALOG    = 3'd3;
    localparam logic [2:0] ACT_TIMESTAMP = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NOT_CAPTURED = 2'd1;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

    // Capture groups
    localparam int         NUM_GROUPS      = 20;
    localparam logic [4:0] GRP_ANALOG_LOW  = 5'd0;
    localparam logic [4:0] GRP_ANALOG_HIGH = 5'd1;
    localparam logic [4:0] GRP_DIGITAL     = 5'd10;
    localparam logic [4:0] GRP_ENC_LOW     = 5'd16;
    localparam logic [4:0] GRP_ENC_HIGH    = 5'd17;
    localparam logic [4:0] GRP_LAST        = 5'd19;

    // Digital channels past the header block skip this many bits
    localparam logic [5:0] HIGH_CHANNEL_SHIFT = 6'd6;

    // Fallback values
    localparam logic signed [RESULT_W-1:0] ANALOG_FALLBACK = 33'sh0_0000_FFFF;
    localparam logic signed [RESULT_W-1:0] ZERO_FALLBACK   = 33'sh0_0000_0000;
    localparam logic signed [RESULT_W-1:0] MINUS_ONE       = -33'sd1;

    // Divider: bits resolved per pass and number of passes
    localparam int DIV_STEPS  = 8;
    localparam int DIV_PASSES = 4;

    // Kind of work the back end does for one queued command
    typedef enum logic [2:0] {
        K_STORE,
        K_IMM,
        K_DIG,
        K_ENC,
        K_ANA,
        K_TS
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [ADDR_W-1:0]          addr;
        logic [WORD_W-1:0]          data;
        logic [4:0]                 sel;
        logic [2:0]                 scale;
        logic [STATUS_W-1:0]        status;
        logic signed [RESULT_W-1:0] value;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_READ,
        BS_DIV
    } t_bstate;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_RUN,
        DS_DONE
    } t_dstate;

    // Words taken by each capture group
    function automatic logic [2:0] group_size(input logic [4:0] grp);
        logic [2:0] size;
        case (grp)
            5'd0, 5'd1, 5'd4, 5'd5, 5'd10: size = 3'd2;
            5'd8, 5'd9:                    size = 3'd3;
            5'd11:                         size = 3'd1;
            default:                       size = 3'd4;
        endcase
        return size;
    endfunction

endpackage

### design/dma_capture_record_decoder.sv
`timescale 1ns / 1ps
// A query is queued, popped and its word read before its result is registered; the next
//   command pops only once that result is loaded. Error results load from the queue,
//   encoder results from the four-pass divider. One store per cycle while the back end idles.
// A mask write starts a layout walk over all 20 groups, one group per cycle, with input stalled.
// Reset (i_rst_n low, synchronous) clears mask, queue and handshakes; record length is one;
//   the record memory is not cleared and holds undefined words until written.
// ----------------------------------------------------------------------------
// dma_capture_record_decoder: captured sample record decoder
// Stores record words and answers digital, encoder, analog and timestamp
// queries from the layout given by the group enable mask.
// ----------------------------------------------------------------------------
module dma_capture_record_decoder #(
    parameter int RECORD_DEPTH    = 66,
    parameter int HEADER_CHANNELS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: group_enable_mask
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_data,
    // Input words
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // action[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    // word_position[6:0], word_data[38:7], channel[43:39], encoder_scale[46:44],
    // zero[47]
    input  logic [47:0] i_s_axis_tdata,
    // Result words
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // result_value[32:0], zero[39:33]
    output logic [39:0] o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]  o_m_axis_tuser
);

    localparam int AW = $clog2(RECORD_DEPTH);

    logic           w_push;
    logic           w_q_full;
    logic           w_sweep_busy;
    dcrd_pkg::t_cmd w_front_cmd;
    logic           w_q_valid;
    logic           w_q_pop;
    dcrd_pkg::t_cmd w_q_cmd;

    logic                           w_ram_we;
    logic                           w_ram_re;
    logic [AW-1:0]                  w_ram_addr;
    logic [dcrd_pkg::WORD_W-1:0]    w_ram_wdata;
    logic [dcrd_pkg::WORD_W-1:0]    w_ram_rdata;

    logic               w_div_start;
    logic               w_div_busy;
    logic               w_div_done;
    logic signed [30:0] w_div_dividend;
    logic [2:0]         w_div_divisor;
    logic signed [30:0] w_div_quotient;

    logic [dcrd_pkg::RESULT_W-1:0] w_value;
    logic [dcrd_pkg::STATUS_W-1:0] w_status;

    assign o_cfg_ready = 1'b1;

    // Accept and classify
    dcrd_front #(
        .RECORD_DEPTH    (RECORD_DEPTH),
        .HEADER_CHANNELS (HEADER_CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (i_s_axis_tvalid),
        .i_s_user    (i_s_axis_tuser),
        .i_s_data    (i_s_axis_tdata),
        .o_s_ready   (o_s_axis_tready),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_front_cmd),
        .o_busy      (w_sweep_busy)
    );

    // Command queue
    dcrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Execute
    dcrd_back #(
        .RECORD_DEPTH (RECORD_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_q_cmd),
        .o_q_pop        (w_q_pop),
        .o_ram_we       (w_ram_we),
        .o_ram_re       (w_ram_re),
        .o_ram_addr     (w_ram_addr),
        .o_ram_wdata    (w_ram_wdata),
        .i_ram_rdata    (w_ram_rdata),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_div_dividend),
        .o_div_divisor  (w_div_divisor),
        .i_div_done     (w_div_done),
        .i_div_quotient (w_div_quotient),
        .o_m_valid      (o_m_axis_tvalid),
        .i_m_ready      (i_m_axis_tready),
        .o_m_value      (w_value),
        .o_m_status     (w_status)
    );

    // Record memory
    dcrd_ram #(
        .WIDTH (dcrd_pkg::WORD_W),
        .DEPTH (RECORD_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_addr),
        .o_rdata (w_ram_rdata)
    );

    // Encoder scale divider
    dcrd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_quotient)
    );

    assign o_m_axis_tdata = {7'b0, w_value};
    assign o_m_axis_tuser = w_status;

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("command pushed into full queue");

    // No word is taken during the layout walk
    a_stall_on_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sweep_busy |-> !o_s_axis_tready)
        else $error("input accepted during layout walk");

    // The divider is started only when idle
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    // A store never writes and reads the memory in the same cycle
    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> !w_ram_re && w_q_pop)
        else $error("memory write without pop or with read");

endmodule

### design/dcrd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dcrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 66
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/dcrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrd_front: input side of the capture record decoder
// Holds the enable mask, walks the group layout after each mask write, and
// classifies accepted words into commands for the back end.
// ----------------------------------------------------------------------------
module dcrd_front #(
    parameter int RECORD_DEPTH    = 66,
    parameter int HEADER_CHANNELS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration
    input  logic                          i_cfg_valid,
    input  logic [dcrd_pkg::MASK_W-1:0]   i_cfg_data,
    // Input words
    input  logic                          i_s_valid,
    // action[2:0]
    input  logic [2:0]                    i_s_user,
    // word_position[6:0], word_data[38:7], channel[43:39], encoder_scale[46:44],
    // zero[47]
    input  logic [47:0]                   i_s_data,
    output logic                          o_s_ready,
    // Command queue side
    input  logic                          i_q_full,
    output logic                          o_push,
    output dcrd_pkg::t_cmd                o_cmd,
    output logic                          o_busy
);

    localparam logic [7:0] DEPTH_L = 8'(RECORD_DEPTH);
    localparam logic [5:0] HDR_L   = 6'(HEADER_CHANNELS);

    logic [dcrd_pkg::MASK_W-1:0] r_mask;
    logic                        r_sweep;
    logic [4:0]                  r_gidx;
    logic [6:0]                  r_acc;
    logic [6:0]                  r_len;
    logic [6:0]                  r_off_ana0;
    logic [6:0]                  r_off_ana1;
    logic [6:0]                  r_off_dig;
    logic [6:0]                  r_off_enc0;
    logic [6:0]                  r_off_enc1;
    logic [6:0]                  n_acc;

    logic [2:0]  w_action;
    logic [6:0]  w_pos;
    logic [31:0] w_data;
    logic [4:0]  w_ch;
    logic [2:0]  w_scale;
    logic [2:0]  w_scale_eff;
    logic [5:0]  w_bit;
    logic        w_grp_ok;
    logic        w_need;
    dcrd_pkg::t_cmd w_cmd;

    // Unpack the input word
    assign w_action = i_s_user;
    assign w_pos    = i_s_data[6:0];
    assign w_data   = i_s_data[38:7];
    assign w_ch     = i_s_data[43:39];
    assign w_scale  = i_s_data[46:44];

    assign w_scale_eff = (w_scale == 3'd0) ? 3'd1 : w_scale;
    assign w_bit = ({1'b0, w_ch} < HDR_L) ? {1'b0, w_ch}
                                          : {1'b0, w_ch} + dcrd_pkg::HIGH_CHANNEL_SHIFT;

    // Advance the layout walk by one group
    assign n_acc = r_acc + (r_mask[r_gidx] ? {4'b0, dcrd_pkg::group_size(r_gidx)} : 7'd0);

    // Mask register and layout walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_sweep <= 1'b0;
            r_gidx  <= '0;
            r_acc   <= '0;
            r_len   <= 7'd1;
        end else if (i_cfg_valid) begin
            r_mask  <= i_cfg_data;
            r_sweep <= 1'b1;
            r_gidx  <= '0;
            r_acc   <= '0;
        end else if (r_sweep) begin
            r_acc  <= n_acc;
            r_gidx <= r_gidx + 5'd1;
            if (r_gidx == dcrd_pkg::GRP_LAST) begin
                r_sweep <= 1'b0;
                r_len   <= n_acc + 7'd1;
            end
        end
    end

    // Capture the offsets of the groups that queries use
    always_ff @(posedge i_clk) begin
        if (r_sweep && !i_cfg_valid) begin
            if (r_gidx == dcrd_pkg::GRP_ANALOG_LOW)  r_off_ana0 <= r_acc;
            if (r_gidx == dcrd_pkg::GRP_ANALOG_HIGH) r_off_ana1 <= r_acc;
            if (r_gidx == dcrd_pkg::GRP_DIGITAL)     r_off_dig  <= r_acc;
            if (r_gidx == dcrd_pkg::GRP_ENC_LOW)     r_off_enc0 <= r_acc;
            if (r_gidx == dcrd_pkg::GRP_ENC_HIGH)    r_off_enc1 <= r_acc;
        end
    end

    // Classify the word into a command
    always_comb begin
        w_cmd        = '0;
        w_cmd.kind   = dcrd_pkg::K_IMM;
        w_cmd.status = dcrd_pkg::ST_OK;
        w_need       = 1'b0;
        w_grp_ok     = 1'b0;
        case (w_action)
            dcrd_pkg::ACT_STORE: begin
                w_cmd.kind = dcrd_pkg::K_STORE;
                w_cmd.addr = w_pos;
                w_cmd.data = w_data;
                w_need     = ({1'b0, w_pos} < DEPTH_L);
            end
            dcrd_pkg::ACT_DIGITAL: begin
                w_need = 1'b1;
                if (!r_mask[dcrd_pkg::GRP_DIGITAL]) begin
                    w_cmd.value  = dcrd_pkg::ZERO_FALLBACK;
                    w_cmd.status = dcrd_pkg::ST_NOT_CAPTURED;
                end else if (w_bit[5]) begin
                    w_cmd.value  = dcrd_pkg::ZERO_FALLBACK;
                    w_cmd.status = dcrd_pkg::ST_OUT_OF_RANGE;
                end else begin
                    w_cmd.kind = dcrd_pkg::K_DIG;
                    w_cmd.addr = r_off_dig;
                    w_cmd.sel  = w_bit[4:0];
                end
            end
            dcrd_pkg::ACT_ENCODER: begin
                w_need   = 1'b1;
                w_grp_ok = w_ch[2] ? r_mask[dcrd_pkg::GRP_ENC_HIGH]
                                   : r_mask[dcrd_pkg::GRP_ENC_LOW];
                if (w_ch[4:3] != 2'd0) begin
                    w_cmd.value  = dcrd_pkg::ZERO_FALLBACK;
                    w_cmd.status = dcrd_pkg::ST_OUT_OF_RANGE;
                end else if (!w_grp_ok) begin
                    // Fallback of -1 divided by the scale
                    w_cmd.value  = (w_scale_eff == 3'd1) ? dcrd_pkg::MINUS_ONE
                                                         : dcrd_pkg::ZERO_FALLBACK;
                    w_cmd.status = dcrd_pkg::ST_NOT_CAPTURED;
                end else begin
                    w_cmd.kind  = dcrd_pkg::K_ENC;
                    w_cmd.addr  = (w_ch[2] ? r_off_enc1 : r_off_enc0) + {5'b0, w_ch[1:0]};
                    w_cmd.scale = w_scale_eff;
                end
            end
            dcrd_pkg::ACT_ANALOG: begin
                w_need   = 1'b1;
                w_grp_ok = w_ch[2] ? r_mask[dcrd_pkg::GRP_ANALOG_HIGH]
                                   : r_mask[dcrd_pkg::GRP_ANALOG_LOW];
                if (w_ch[4:3] != 2'd0) begin
                    w_cmd.value  = dcrd_pkg::ANALOG_FALLBACK;
                    w_cmd.status = dcrd_pkg::ST_OUT_OF_RANGE;
                end else if (!w_grp_ok) begin
                    w_cmd.value  = dcrd_pkg::ANALOG_FALLBACK;
                    w_cmd.status = dcrd_pkg::ST_NOT_CAPTURED;
                end else begin
                    w_cmd.kind = dcrd_pkg::K_ANA;
                    w_cmd.addr = (w_ch[2] ? r_off_ana1 : r_off_ana0) + {6'b0, w_ch[1]};
                    w_cmd.sel  = {4'b0, w_ch[0]};
                end
            end
            dcrd_pkg::ACT_TIMESTAMP: begin
                w_need     = 1'b1;
                w_cmd.kind = dcrd_pkg::K_TS;
                w_cmd.addr = r_len - 7'd1;
            end
            default: begin
                w_need = 1'b0;
            end
        endcase
    end

    // Stall input during the layout walk or when the queue is full
    assign o_s_ready = !r_sweep && !i_q_full;
    assign o_push    = i_s_valid && o_s_ready && w_need;
    assign o_cmd     = w_cmd;
    assign o_busy    = r_sweep;

endmodule

### design/dcrd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrd_queue: two-entry command queue
// Decouples classification from execution so each side stalls on its own.
// ----------------------------------------------------------------------------
module dcrd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dcrd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dcrd_pkg::t_cmd o_cmd
);

    dcrd_pkg::t_cmd r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

endmodule

### design/dcrd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrd_div: small signed divider for encoder counts
// Divides a 31-bit signed count by a 3-bit divisor, truncating toward zero.
// Resolves eight quotient bits per cycle over four passes.
// ----------------------------------------------------------------------------
module dcrd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [30:0] i_dividend,
    input  logic [2:0]         i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic signed [30:0] o_quotient
);

    dcrd_pkg::t_dstate r_state;
    dcrd_pkg::t_dstate n_state;
    logic [1:0]  r_pass;
    logic [31:0] r_quo;
    logic [2:0]  r_rem;
    logic [2:0]  r_div;
    logic        r_neg;
    logic [31:0] n_quo;
    logic [2:0]  n_rem;
    logic [30:0] w_mag;
    logic [31:0] w_res;

    // Magnitude of the dividend
    assign w_mag = i_dividend[30] ? 31'(-i_dividend) : i_dividend;

    // One pass of restoring division, eight bits
    always_comb begin
        logic [3:0]  trial;
        logic [31:0] sh;
        logic [2:0]  rem;
        sh  = r_quo;
        rem = r_rem;
        for (int i = 0; i < dcrd_pkg::DIV_STEPS; i++) begin
            trial = {rem, sh[31]};
            sh    = {sh[30:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                rem   = 3'(trial - {1'b0, r_div});
                sh[0] = 1'b1;
            end else begin
                rem = trial[2:0];
            end
        end
        n_quo = sh;
        n_rem = rem;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dcrd_pkg::DS_IDLE: if (i_start) n_state = dcrd_pkg::DS_RUN;
            dcrd_pkg::DS_RUN: begin
                if (r_pass == 2'(dcrd_pkg::DIV_PASSES - 1)) n_state = dcrd_pkg::DS_DONE;
            end
            dcrd_pkg::DS_DONE: n_state = dcrd_pkg::DS_IDLE;
            default:           n_state = dcrd_pkg::DS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            dcrd_pkg::DS_IDLE: o_busy = 1'b0;
            dcrd_pkg::DS_RUN:  o_busy = 1'b1;
            dcrd_pkg::DS_DONE: o_done = 1'b1;
            default:           o_busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcrd_pkg::DS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: load on start, shift on each pass
    always_ff @(posedge i_clk) begin
        if (r_state == dcrd_pkg::DS_IDLE && i_start) begin
            r_quo  <= {1'b0, w_mag};
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_neg  <= i_dividend[30];
            r_pass <= '0;
        end else if (r_state == dcrd_pkg::DS_RUN) begin
            r_quo  <= n_quo;
            r_rem  <= n_rem;
            r_pass <= r_pass + 2'd1;
        end
    end

    // Apply the sign to the magnitude quotient
    assign w_res      = r_neg ? -r_quo : r_quo;
    assign o_quotient = w_res[30:0];

endmodule

### design/dcrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrd_back: execution side of the capture record decoder
// Pops commands, writes and reads the record memory, runs the divider for
// encoder counts, and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module dcrd_back #(
    parameter int RECORD_DEPTH = 66
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Command queue
    input  logic                                 i_q_valid,
    input  dcrd_pkg::t_cmd                       i_q_cmd,
    output logic                                 o_q_pop,
    // Record memory
    output logic                                 o_ram_we,
    output logic                                 o_ram_re,
    output logic [$clog2(RECORD_DEPTH)-1:0]      o_ram_addr,
    output logic [dcrd_pkg::WORD_W-1:0]          o_ram_wdata,
    input  logic [dcrd_pkg::WORD_W-1:0]          i_ram_rdata,
    // Divider
    output logic                                 o_div_start,
    output logic signed [30:0]                   o_div_dividend,
    output logic [2:0]                           o_div_divisor,
    input  logic                                 i_div_done,
    input  logic signed [30:0]                   i_div_quotient,
    // Result words
    output logic                                 o_m_valid,
    input  logic                                 i_m_ready,
    output logic [dcrd_pkg::RESULT_W-1:0]        o_m_value,
    output logic [dcrd_pkg::STATUS_W-1:0]        o_m_status
);

    localparam int AW = $clog2(RECORD_DEPTH);

    dcrd_pkg::t_bstate r_state;
    dcrd_pkg::t_bstate n_state;
    dcrd_pkg::t_kind   r_kind;
    logic [4:0]        r_sel;
    logic [2:0]        r_scale;

    logic                                r_out_valid;
    logic signed [dcrd_pkg::RESULT_W-1:0] r_out_value;
    logic [dcrd_pkg::STATUS_W-1:0]       r_out_status;

    logic                                w_out_free;
    logic                                w_load;
    logic signed [dcrd_pkg::RESULT_W-1:0] w_value;
    logic [dcrd_pkg::STATUS_W-1:0]       w_status;

    assign w_out_free = !r_out_valid || i_m_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dcrd_pkg::BS_IDLE: begin
                if (i_q_valid && w_out_free && i_q_cmd.kind != dcrd_pkg::K_STORE &&
                    i_q_cmd.kind != dcrd_pkg::K_IMM) begin
                    n_state = dcrd_pkg::BS_READ;
                end
            end
            dcrd_pkg::BS_READ: begin
                n_state = (r_kind == dcrd_pkg::K_ENC) ? dcrd_pkg::BS_DIV : dcrd_pkg::BS_IDLE;
            end
            dcrd_pkg::BS_DIV: if (i_div_done) n_state = dcrd_pkg::BS_IDLE;
            default:          n_state = dcrd_pkg::BS_IDLE;
        endcase
    end

    // Outputs: pop, memory access, divider start, result load
    always_comb begin
        o_q_pop     = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;
        o_div_start = 1'b0;
        w_load      = 1'b0;
        w_value     = dcrd_pkg::ZERO_FALLBACK;
        w_status    = dcrd_pkg::ST_OK;
        case (r_state)
            dcrd_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.kind == dcrd_pkg::K_STORE) begin
                        o_q_pop  = 1'b1;
                        o_ram_we = 1'b1;
                    end else if (w_out_free) begin
                        o_q_pop = 1'b1;
                        if (i_q_cmd.kind == dcrd_pkg::K_IMM) begin
                            w_load   = 1'b1;
                            w_value  = i_q_cmd.value;
                            w_status = i_q_cmd.status;
                        end else begin
                            o_ram_re = 1'b1;
                        end
                    end
                end
            end
            dcrd_pkg::BS_READ: begin
                case (r_kind)
                    dcrd_pkg::K_DIG: begin
                        w_load  = 1'b1;
                        w_value = {32'b0, i_ram_rdata[r_sel]};
                    end
                    dcrd_pkg::K_ANA: begin
                        w_load  = 1'b1;
                        w_value = r_sel[0] ? {17'b0, i_ram_rdata[31:16]}
                                           : {17'b0, i_ram_rdata[15:0]};
                    end
                    dcrd_pkg::K_ENC: o_div_start = 1'b1;
                    default: begin
                        w_load  = 1'b1;
                        w_value = {1'b0, i_ram_rdata};
                    end
                endcase
            end
            dcrd_pkg::BS_DIV: begin
                if (i_div_done) begin
                    w_load  = 1'b1;
                    w_value = {{2{i_div_quotient[30]}}, i_div_quotient};
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcrd_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the popped command's controls during the read
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_kind  <= i_q_cmd.kind;
            r_sel   <= i_q_cmd.sel;
            r_scale <= i_q_cmd.scale;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value  <= w_value;
            r_out_status <= w_status;
        end
    end

    assign o_ram_addr     = i_q_cmd.addr[AW-1:0];
    assign o_ram_wdata    = i_q_cmd.data;
    // Count is the word shifted right by one, arithmetic
    assign o_div_dividend = i_ram_rdata[31:1];
    assign o_div_divisor  = r_scale;

    assign o_m_valid  = r_out_valid;
    assign o_m_value  = r_out_value;
    assign o_m_status = r_out_status;

endmodule

### bench/capture_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_record_checker: result predictor and scoreboard for the decoder
// Watches the mask, input and result channels at the rising edge. It keeps
// its own copy of the record and the mask and works out the answer to every
// accepted query. It compares each accepted result with the oldest answer
// still owed, and hands a failure count and the number owed to the top.
// ----------------------------------------------------------------------------
module capture_record_checker #(
    parameter int RECORD_DEPTH    = 66,
    parameter int HEADER_CHANNELS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    // action[2:0]
    input  logic [2:0]  i_in_user,
    // word_position[6:0], word_data[38:7], channel[43:39], encoder_scale[46:44],
    // zero[47]
    input  logic [47:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    // result_value[32:0], zero[39:33]
    input  logic [39:0] i_out_data,
    // status[1:0]
    input  logic [1:0]  i_out_user,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  position;
        logic [31:0] data;
        logic [4:0]  channel;
        logic [2:0]  scale;
    } t_query;

    typedef struct packed {
        logic signed [dcrd_pkg::RESULT_W-1:0] value;
        logic [dcrd_pkg::STATUS_W-1:0]        status;
    } t_answer;

    // Shadow of the block's state
    logic [31:0]                 record_mem [RECORD_DEPTH];
    logic [dcrd_pkg::MASK_W-1:0] enable_mask;
    t_answer                     owed_answers [$];

    // Words taken by each capture group
    function automatic int words_of_group(input int grp);
        case (grp)
            0, 1, 4, 5, 10: return 2;
            8, 9:           return 3;
            11:             return 1;
            default:        return 4;
        endcase
    endfunction

    // First word of a group: sum of enabled groups below it; the timestamp
    // word sits at the base of the group past the last one
    function automatic int group_base(input int grp);
        int acc;
        acc = 0;
        for (int g = 0; g < grp; g++) begin
            if (enable_mask[g]) begin
                acc += words_of_group(g);
            end
        end
        return acc;
    endfunction

    function automatic logic [31:0] fetch(input int pos);
        return (pos < RECORD_DEPTH) ? record_mem[pos] : 32'd0;
    endfunction

    // Answer one query against the current record and layout
    function automatic t_answer answer_query(input t_query q);
        t_answer    ans;
        logic [31:0] w;
        logic [4:0] grp;
        longint     count;
        longint     divisor;
        int         bitpos;
        ans.value  = dcrd_pkg::ZERO_FALLBACK;
        ans.status = dcrd_pkg::ST_OK;
        case (q.action)
            dcrd_pkg::ACT_DIGITAL: begin
                bitpos = (int'(q.channel) < HEADER_CHANNELS) ? int'(q.channel) :
                         int'(q.channel) + int'(dcrd_pkg::HIGH_CHANNEL_SHIFT);
                if (!enable_mask[dcrd_pkg::GRP_DIGITAL]) begin
                    ans.status = dcrd_pkg::ST_NOT_CAPTURED;
                end else if (bitpos > 31) begin
                    ans.status = dcrd_pkg::ST_OUT_OF_RANGE;
                end else begin
                    w = fetch(group_base(dcrd_pkg::GRP_DIGITAL));
                    ans.value = {32'd0, w[bitpos]};
                end
            end
            dcrd_pkg::ACT_ENCODER: begin
                grp     = (q.channel < 5'd4) ? dcrd_pkg::GRP_ENC_LOW : dcrd_pkg::GRP_ENC_HIGH;
                divisor = (q.scale == 3'd0) ? 64'sd1 : longint'(q.scale);
                if (q.channel >= 5'd8) begin
                    ans.status = dcrd_pkg::ST_OUT_OF_RANGE;
                end else begin
                    if (!enable_mask[grp]) begin
                        ans.status = dcrd_pkg::ST_NOT_CAPTURED;
                        count = longint'(dcrd_pkg::MINUS_ONE) / divisor;
                    end else begin
                        // Drop the low bit, keep the sign, truncate toward zero
                        w = fetch(group_base(grp) + int'(q.channel[1:0]));
                        count = longint'($signed(w) >>> 1) / divisor;
                    end
                    ans.value = count[dcrd_pkg::RESULT_W-1:0];
                end
            end
            dcrd_pkg::ACT_ANALOG: begin
                grp       = (q.channel < 5'd4) ? dcrd_pkg::GRP_ANALOG_LOW :
                                                 dcrd_pkg::GRP_ANALOG_HIGH;
                ans.value = dcrd_pkg::ANALOG_FALLBACK;
                if (q.channel >= 5'd8) begin
                    ans.status = dcrd_pkg::ST_OUT_OF_RANGE;
                end else if (!enable_mask[grp]) begin
                    ans.status = dcrd_pkg::ST_NOT_CAPTURED;
                end else begin
                    // Two channels per word, odd channel in the upper half
                    w = fetch(group_base(grp) + int'(q.channel[1]));
                    ans.value = {17'd0, q.channel[0] ? w[31:16] : w[15:0]};
                end
            end
            dcrd_pkg::ACT_TIMESTAMP: begin
                ans.value = {1'b0, fetch(group_base(dcrd_pkg::NUM_GROUPS))};
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Track handshakes at the rising edge
    always @(posedge i_clk) begin : observe
        t_query  q;
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            enable_mask = '0;
            owed_answers.delete();
        end else begin
            // Compare an accepted result with the oldest answer owed
            if (i_out_valid && i_out_ready) begin
                got.value  = i_out_data[32:0];
                got.status = i_out_user;
                if (owed_answers.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected result word: value %0d status %0d",
                                 $signed(got.value), got.status);
                    end
                    o_fail_count++;
                end else begin
                    want = owed_answers.pop_front();
                    if (got.value !== want.value || got.status !== want.status) begin
                        if (o_fail_count < 10) begin
                            $display({"result mismatch: expected value %0d status %0d, ",
                                      "got value %0d status %0d"},
                                     $signed(want.value), want.status,
                                     $signed(got.value), got.status);
                        end
                        o_fail_count++;
                    end
                end
            end
            // New layout takes effect at once
            if (i_cfg_valid && i_cfg_ready) begin
                enable_mask = i_cfg_data;
            end
            // Store a word or owe an answer to a query
            if (i_in_valid && i_in_ready) begin
                q.action   = i_in_user;
                q.position = i_in_data[6:0];
                q.data     = i_in_data[38:7];
                q.channel  = i_in_data[43:39];
                q.scale    = i_in_data[46:44];
                case (q.action)
                    dcrd_pkg::ACT_STORE: begin
                        if (int'(q.position) < RECORD_DEPTH) begin
                            record_mem[q.position] = q.data;
                        end
                    end
                    dcrd_pkg::ACT_DIGITAL, dcrd_pkg::ACT_ENCODER,
                    dcrd_pkg::ACT_ANALOG, dcrd_pkg::ACT_TIMESTAMP: begin
                        owed_answers.push_back(answer_query(q));
                    end
                    default: ;
                endcase
            end
        end
        o_pending = owed_answers.size();
    end

endmodule

### bench/tb_dma_capture_record_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dma_capture_record_decoder: stimulus and verdict for the record decoder
// Fills the record, runs a directed set of queries at the edges of every
// field, then random stores and queries under a series of enable masks.
// Both stream sides idle at random; one long result stall backs the block
// up, and one sender pause lets it drain. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_dma_capture_record_decoder;

    localparam int ITEMS_PER_PHASE = 220;
    localparam int NUM_PHASES      = 8;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_CYCLES     = 300;
    localparam int TIMEOUT_NS      = 5_000_000;
    // Word positions with every group enabled
    localparam logic [6:0] DIG_POS_ALL = 7'd30;
    localparam logic [6:0] ENC_POS_ALL = 7'd49;
    localparam logic [6:0] TS_POS_ALL  = 7'd65;
    localparam logic [6:0] POS_TOP     = 7'd127;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [19:0] cfg_data;
    logic        in_tvalid;
    logic        in_tready;
    logic [2:0]  in_tuser;
    logic [47:0] in_tdata;
    logic        out_tvalid;
    logic        out_tready;
    logic [39:0] out_tdata;
    logic [1:0]  out_tuser;
    int          fail_count;
    int          pending;
    bit          quiet_sender;
    bit          quiet_receiver;
    bit          hold_results;

    dma_capture_record_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (in_tvalid),
        .o_s_axis_tready (in_tready),
        .i_s_axis_tuser  (in_tuser),
        .i_s_axis_tdata  (in_tdata),
        .o_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready),
        .o_m_axis_tdata  (out_tdata),
        .o_m_axis_tuser  (out_tuser)
    );

    capture_record_checker record_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_tvalid),
        .i_in_ready   (in_tready),
        .i_in_user    (in_tuser),
        .i_in_data    (in_tdata),
        .i_out_valid  (out_tvalid),
        .i_out_ready  (out_tready),
        .i_out_data   (out_tdata),
        .i_out_user   (out_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run time
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // Action in the low three bits, stream data above it
    function automatic logic [50:0] pack_word(input logic [2:0] action,
                                              input logic [6:0] pos,
                                              input logic [31:0] data,
                                              input logic [4:0] ch,
                                              input logic [2:0] scale);
        return {scale, ch, data, pos, action};
    endfunction

    // Offer one word after a random gap; return at the falling edge after
    // it is taken, with valid still high
    task automatic send_word(input logic [50:0] word);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_tvalid <= 1'b1;
        in_tuser  <= word[2:0];
        in_tdata  <= {1'b0, word[50:3]};
        do @(posedge clk); while (!in_tready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every result owed is out and the block
    // has finished any trailing store
    task automatic drain_results();
        in_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mask(input logic [19:0] mask);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall per word, with an occasional long hold
    initial begin : receiver
        int stall;
        int taken;
        out_tready = 1'b0;
        taken      = 0;
        @(negedge clk);
        forever begin
            stall = quiet_receiver ? 0 : $urandom_range(0, 12);
            if (hold_results) begin
                stall += HOLD_CYCLES;
                hold_results = 1'b0;
            end
            if (stall > 0) begin
                out_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_tready <= 1'b1;
            do @(posedge clk); while (!out_tvalid);
            @(negedge clk);
            taken++;
            if (taken % 40 == 0) begin
                quiet_receiver = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [19:0] phase_masks [NUM_PHASES];
        logic [2:0]  action;
        logic [6:0]  pos;
        logic [31:0] data;
        logic [4:0]  ch;
        logic [2:0]  scale;
        int          pick;
        int          n;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_tvalid = 1'b0;
        in_tuser  = '0;
        in_tdata  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Write every record word once so no query reads an unwritten word
        for (int p = 0; p <= int'(TS_POS_ALL); p++) begin
            send_word(pack_word(dcrd_pkg::ACT_STORE, 7'(p), $urandom, 5'd0, 3'd1));
        end

        // Reset layout: nothing captured, timestamp is word zero
        send_word(pack_word(dcrd_pkg::ACT_DIGITAL, 7'd0, 32'd0, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_ENCODER, 7'd0, 32'd0, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_ENCODER, 7'd0, 32'd0, 5'd0, 3'd2));
        send_word(pack_word(dcrd_pkg::ACT_ANALOG, 7'd0, 32'd0, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_TIMESTAMP, 7'd0, 32'd0, 5'd0, 3'd1));

        // Every group captured: digital bits, low and high channels, past bit 31
        write_mask(20'hFFFFF);
        send_word(pack_word(dcrd_pkg::ACT_STORE, DIG_POS_ALL, 32'h8000_0201, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_DIGITAL, 7'd0, 32'd0, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_DIGITAL, 7'd0, 32'd0, 5'd9, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_DIGITAL, 7'd0, 32'd0, 5'd10, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_DIGITAL, 7'd0, 32'd0, 5'd25, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_DIGITAL, 7'd0, 32'd0, 5'd26, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_DIGITAL, 7'd0, 32'd0, 5'd31, 3'd1));
        // Encoders: most negative count, zero scale, largest count, bad index
        send_word(pack_word(dcrd_pkg::ACT_STORE, ENC_POS_ALL, 32'h8000_0000, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_ENCODER, 7'd0, 32'd0, 5'd0, 3'd0));
        send_word(pack_word(dcrd_pkg::ACT_ENCODER, 7'd0, 32'd0, 5'd0, 3'd3));
        send_word(pack_word(dcrd_pkg::ACT_STORE, ENC_POS_ALL + 7'd3, 32'h7FFF_FFFF,
                            5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_ENCODER, 7'd0, 32'd0, 5'd3, 3'd4));
        send_word(pack_word(dcrd_pkg::ACT_ENCODER, 7'd0, 32'd0, 5'd7, 3'd7));
        send_word(pack_word(dcrd_pkg::ACT_ENCODER, 7'd0, 32'd0, 5'd8, 3'd1));
        // Analog halves and out-of-range channels
        send_word(pack_word(dcrd_pkg::ACT_STORE, 7'd0, 32'h1234_ABCD, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_ANALOG, 7'd0, 32'd0, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_ANALOG, 7'd0, 32'd0, 5'd1, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_ANALOG, 7'd0, 32'd0, 5'd7, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_ANALOG, 7'd0, 32'd0, 5'd8, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_ANALOG, 7'd0, 32'd0, 5'd31, 3'd1));
        // Timestamp in the last word; stores past the record are dropped
        send_word(pack_word(dcrd_pkg::ACT_STORE, TS_POS_ALL, 32'hFFFF_FFFF, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_TIMESTAMP, 7'd0, 32'd0, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_STORE, POS_TOP, 32'h0000_0000, 5'd0, 3'd1));
        send_word(pack_word(dcrd_pkg::ACT_TIMESTAMP, 7'd0, 32'd0, 5'd0, 3'd1));
        send_word(pack_word(3'd7, 7'd0, 32'd0, 5'd0, 3'd1));

        // Random traffic under a series of layouts
        phase_masks[0] = 20'h30403;
        phase_masks[1] = 20'($urandom_range(0, 20'hFFFFF));
        phase_masks[2] = 20'h00000;
        phase_masks[3] = 20'($urandom_range(0, 20'hFFFFF));
        phase_masks[4] = 20'hFFFFF;
        phase_masks[5] = 20'h20400;
        phase_masks[6] = 20'($urandom_range(0, 20'hFFFFF));
        phase_masks[7] = 20'hCFBFC;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_mask(phase_masks[p]);
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                if (n % 50 == 0) begin
                    quiet_sender = ($urandom_range(0, 3) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 25)      action = dcrd_pkg::ACT_STORE;
                else if (pick < 40) action = dcrd_pkg::ACT_DIGITAL;
                else if (pick < 58) action = dcrd_pkg::ACT_ENCODER;
                else if (pick < 78) action = dcrd_pkg::ACT_ANALOG;
                else if (pick < 88) action = dcrd_pkg::ACT_TIMESTAMP;
                else action = 3'($urandom_range(int'(dcrd_pkg::ACT_TIMESTAMP) + 1, 7));
                pos = ($urandom_range(0, 9) == 0) ?
                      7'($urandom_range(int'(TS_POS_ALL) + 1, int'(POS_TOP))) :
                      7'($urandom_range(0, int'(TS_POS_ALL)));
                case ($urandom_range(0, 7))
                    0:       data = 32'h0000_0000;
                    1:       data = 32'hFFFF_FFFF;
                    2:       data = 32'h8000_0000;
                    3:       data = 32'h7FFF_FFFF;
                    default: data = $urandom;
                endcase
                // Mostly channels in range, the rest anywhere
                ch = (action == dcrd_pkg::ACT_DIGITAL || $urandom_range(0, 3) == 0) ?
                     5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
                scale = ($urandom_range(0, 4) == 0) ?
                        3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
                send_word(pack_word(action, pos, data, ch, scale));
                if (action <= dcrd_pkg::ACT_TIMESTAMP) begin
                    n++;
                    // Back up the block with a long result stall
                    if (p == 1 && n == 100) hold_results = 1'b1;
                    // Let the block drain completely mid-phase
                    if (p == 2 && n == 120) drain_results();
                end
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
design/dcrd_pkg.sv
design/dcrd_ram.sv
design/dcrd_front.sv
design/dcrd_queue.sv
design/dcrd_div.sv
design/dcrd_back.sv
design/dma_capture_record_decoder.sv
bench/capture_record_checker.sv
bench/tb_dma_capture_record_decoder.sv
